// ----- hdl/chm_pkg.sv -----
`default_nettype none

package chm_pkg;

  // Address source for read port A of the point store.
  typedef enum logic [1:0] {
    RA_I   = 2'd0,
    RA_JM1 = 2'd1,
    RA_IDX = 2'd2,
    RA_STK = 2'd3
  } st_rd_sel_t;

  // Address pair for the two read ports of the chain stack.
  typedef enum logic [1:0] {
    SK_TOP  = 2'd0,
    SK_BASE = 2'd1,
    SK_OUT  = 2'd2
  } stk_rd_sel_t;

  typedef struct packed {
    logic        load;
    logic        i_set1;
    logic        i_clr;
    logic        i_inc;
    logic        j_from_i;
    logic        j_dec;
    logic        key_ld;
    logic        st_wr_key;
    logic        st_wr_prev;
    logic        ch_init;
    logic        pass_end;
    logic        c_ld;
    logic        diff_ld;
    logic        prod_ld;
    logic        t_dec;
    logic        push;
    logic        single;
    logic        m_from_t;
    logic        m_one;
    logic        out_ld;
    logic        run_clr;
    st_rd_sel_t  st_rd_a;
    stk_rd_sel_t stk_rd;
  } cmd_t;

  typedef struct packed {
    logic i_ge_n;
    logic j_zero;
    logic key_less;
    logic n_le1;
    logic k_ge_n;
    logic pass1;
    logic can_pop;
    logic turn_le0;
    logic t_eq2;
    logic pts_eq;
    logic out_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/chm_ifs.sv -----
`default_nettype none

interface chm_point_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         set_end;

  modport source (output valid, output point_x, output point_y, output set_end,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input set_end,
                output ready);
endinterface

interface chm_hull_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] hull_x;
  logic signed [COORD_BITS-1:0] hull_y;
  logic                         hull_last;
  logic                         points_dropped;

  modport source (output valid, output hull_x, output hull_y, output hull_last,
                  output points_dropped, input ready);
  modport sink (input valid, input hull_x, input hull_y, input hull_last,
                input points_dropped, output ready);
endinterface

`default_nettype wire

// ----- hdl/chm_ctrl.sv -----
`default_nettype none

module chm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_set_end,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output chm_pkg::cmd_t      cmd,
  input  wire chm_pkg::sts_t sts
);

  typedef enum logic [18:0] {
    ST_LOAD    = 19'h00001,
    ST_SCHK    = 19'h00002,
    ST_SKEY    = 19'h00004,
    ST_SRD     = 19'h00008,
    ST_SCMP    = 19'h00010,
    ST_CHINIT  = 19'h00020,
    ST_CHK     = 19'h00040,
    ST_CHC     = 19'h00080,
    ST_CHTEST  = 19'h00100,
    ST_CHSP    = 19'h00200,
    ST_CHD     = 19'h00400,
    ST_CHM     = 19'h00800,
    ST_CHE     = 19'h01000,
    ST_CHPUSH  = 19'h02000,
    ST_FIN     = 19'h04000,
    ST_FINSP   = 19'h08000,
    ST_FINEQ   = 19'h10000,
    ST_OUTSTK  = 19'h20000,
    ST_OUTWAIT = 19'h40000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_pt_r, out_pt_nxt;
  logic   out_ld_r, out_ld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      out_pt_r <= 1'b0;
      out_ld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      out_pt_r <= out_pt_nxt;
      out_ld_r <= out_ld_nxt;
    end
  end

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_OUTWAIT) && !out_pt_r && !out_ld_r;

  always_comb begin
    state_nxt   = state_r;
    out_pt_nxt  = 1'b0;
    out_ld_nxt  = 1'b0;
    cmd         = '0;
    cmd.st_rd_a = chm_pkg::RA_I;
    cmd.stk_rd  = chm_pkg::SK_TOP;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_set_end) begin
            cmd.i_set1 = 1'b1;
            state_nxt  = ST_SCHK;
          end
        end
      end
      ST_SCHK: begin
        cmd.st_rd_a = chm_pkg::RA_I;
        state_nxt   = sts.i_ge_n ? ST_CHINIT : ST_SKEY;
      end
      ST_SKEY: begin
        cmd.key_ld   = 1'b1;
        cmd.j_from_i = 1'b1;
        state_nxt    = ST_SRD;
      end
      ST_SRD: begin
        if (sts.j_zero) begin
          cmd.st_wr_key = 1'b1;
          cmd.i_inc     = 1'b1;
          state_nxt     = ST_SCHK;
        end else begin
          cmd.st_rd_a = chm_pkg::RA_JM1;
          state_nxt   = ST_SCMP;
        end
      end
      ST_SCMP: begin
        if (sts.key_less) begin
          cmd.st_wr_prev = 1'b1;
          cmd.j_dec      = 1'b1;
          state_nxt      = ST_SRD;
        end else begin
          cmd.st_wr_key = 1'b1;
          cmd.i_inc     = 1'b1;
          state_nxt     = ST_SCHK;
        end
      end
      ST_CHINIT: begin
        if (sts.n_le1) begin
          cmd.single = 1'b1;
          cmd.i_clr  = 1'b1;
          state_nxt  = ST_OUTSTK;
        end else begin
          cmd.ch_init = 1'b1;
          state_nxt   = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.st_rd_a = chm_pkg::RA_IDX;
        if (sts.k_ge_n) begin
          cmd.pass_end = 1'b1;
          state_nxt    = sts.pass1 ? ST_FIN : ST_CHK;
        end else begin
          state_nxt = ST_CHC;
        end
      end
      ST_CHC: begin
        cmd.c_ld  = 1'b1;
        state_nxt = ST_CHTEST;
      end
      ST_CHTEST: begin
        cmd.stk_rd = chm_pkg::SK_TOP;
        state_nxt  = sts.can_pop ? ST_CHSP : ST_CHPUSH;
      end
      ST_CHSP: begin
        cmd.st_rd_a = chm_pkg::RA_STK;
        state_nxt   = ST_CHD;
      end
      ST_CHD: begin
        cmd.diff_ld = 1'b1;
        state_nxt   = ST_CHM;
      end
      ST_CHM: begin
        cmd.prod_ld = 1'b1;
        state_nxt   = ST_CHE;
      end
      ST_CHE: begin
        if (sts.turn_le0) begin
          cmd.t_dec = 1'b1;
          state_nxt = ST_CHTEST;
        end else begin
          state_nxt = ST_CHPUSH;
        end
      end
      ST_CHPUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_FIN: begin
        cmd.m_from_t = 1'b1;
        cmd.stk_rd   = chm_pkg::SK_BASE;
        cmd.i_clr    = 1'b1;
        state_nxt    = sts.t_eq2 ? ST_FINSP : ST_OUTSTK;
      end
      ST_FINSP: begin
        cmd.st_rd_a = chm_pkg::RA_STK;
        state_nxt   = ST_FINEQ;
      end
      ST_FINEQ: begin
        cmd.m_one = sts.pts_eq;
        state_nxt = ST_OUTSTK;
      end
      ST_OUTSTK: begin
        cmd.stk_rd = chm_pkg::SK_OUT;
        out_pt_nxt = 1'b1;
        state_nxt  = ST_OUTWAIT;
      end
      ST_OUTWAIT: begin
        // Before the vertex is offered, this state waits for the stack read and then the store read.
        if (out_pt_r) begin
          cmd.st_rd_a = chm_pkg::RA_STK;
          out_ld_nxt  = 1'b1;
        end else if (out_ld_r) begin
          cmd.out_ld = 1'b1;
        end else if (out_ready) begin
          cmd.i_inc = 1'b1;
          if (sts.out_last) begin
            cmd.run_clr = 1'b1;
            state_nxt   = ST_LOAD;
          end else begin
            state_nxt = ST_OUTSTK;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/chm_dp.sv -----
`default_nettype none

module chm_dp #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire chm_pkg::cmd_t                cmd,
  output chm_pkg::sts_t                     sts,
  input  wire logic signed [COORD_BITS-1:0] in_x,
  input  wire logic signed [COORD_BITS-1:0] in_y,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic                              out_last,
  output logic                              out_dropped
);

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int TW  = $clog2(MAX_POINTS + 2);
  localparam int SAW = $clog2(MAX_POINTS + 1);
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;

  logic signed [COORD_BITS-1:0] store_x_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] store_y_mem [MAX_POINTS];
  logic [AW-1:0]                stack_mem [MAX_POINTS+1];

  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic [CW-1:0] i_r;
  logic [AW-1:0] j_r;
  logic [CW-1:0] k_r;
  logic          pass_r;
  logic [TW-1:0] t_r;
  logic [TW-1:0] s_r;
  logic [TW-1:0] m_r;

  logic signed [COORD_BITS-1:0] key_x_r, key_y_r, c_x_r, c_y_r;
  logic signed [COORD_BITS-1:0] rda_x_r, rda_y_r, rdb_x_r, rdb_y_r;
  logic [AW-1:0]                stka_r, stkb_r;
  logic signed [DW-1:0]         bx_r, by_r, cx_r, cy_r;
  logic signed [PW-1:0]         p1_r, p2_r;
  logic signed [PW:0]           turn;
  logic signed [COORD_BITS-1:0] hx_r, hy_r;
  logic                         hlast_r, hdrop_r;

  logic [AW-1:0]                idx;
  logic [AW-1:0]                rda_addr;
  logic [SAW-1:0]               stka_addr, stkb_addr;
  logic                         st_we;
  logic [AW-1:0]                st_waddr;
  logic signed [COORD_BITS-1:0] st_wx, st_wy;
  logic                         stk_we;
  logic [SAW-1:0]               stk_waddr;
  logic [AW-1:0]                stk_wdata;
  logic [CW-1:0]                k_rev;

  assign k_rev = count_r - CW'(1) - k_r;
  assign idx   = pass_r ? k_rev[AW-1:0] : k_r[AW-1:0];

  always_comb begin
    case (cmd.st_rd_a)
      chm_pkg::RA_I:   rda_addr = i_r[AW-1:0];
      chm_pkg::RA_JM1: rda_addr = j_r - AW'(1);
      chm_pkg::RA_IDX: rda_addr = idx;
      chm_pkg::RA_STK: rda_addr = stka_r;
      default:         rda_addr = i_r[AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd.stk_rd)
      chm_pkg::SK_TOP: begin
        stka_addr = SAW'(t_r - TW'(2));
        stkb_addr = SAW'(t_r - TW'(1));
      end
      chm_pkg::SK_BASE: begin
        stka_addr = '0;
        stkb_addr = SAW'(1);
      end
      chm_pkg::SK_OUT: begin
        stka_addr = i_r[SAW-1:0];
        stkb_addr = i_r[SAW-1:0];
      end
      default: begin
        stka_addr = '0;
        stkb_addr = '0;
      end
    endcase
  end

  // Point store write port: loading, or an insertion sort shift or key placement.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = j_r;
    st_wx    = key_x_r;
    st_wy    = key_y_r;
    if (cmd.load && (count_r < CW'(MAX_POINTS))) begin
      st_we    = 1'b1;
      st_waddr = count_r[AW-1:0];
      st_wx    = in_x;
      st_wy    = in_y;
    end else if (cmd.st_wr_key) begin
      st_we = 1'b1;
    end else if (cmd.st_wr_prev) begin
      st_we = 1'b1;
      st_wx = rda_x_r;
      st_wy = rda_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_x_mem[st_waddr] <= st_wx;
      store_y_mem[st_waddr] <= st_wy;
    end
    rda_x_r <= store_x_mem[rda_addr];
    rda_y_r <= store_y_mem[rda_addr];
    rdb_x_r <= store_x_mem[stkb_r];
    rdb_y_r <= store_y_mem[stkb_r];
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = t_r[SAW-1:0];
    stk_wdata = idx;
    if (cmd.single) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = '0;
    end else if (cmd.push && (t_r <= TW'(MAX_POINTS))) begin
      stk_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stka_r <= stack_mem[stka_addr];
    stkb_r <= stack_mem[stkb_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.run_clr) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load) begin
      if (count_r < CW'(MAX_POINTS)) begin
        count_r <= count_r + CW'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.i_set1) begin
      i_r <= CW'(1);
    end else if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + CW'(1);
    end
    if (cmd.j_from_i) begin
      j_r <= i_r[AW-1:0];
    end else if (cmd.j_dec) begin
      j_r <= j_r - AW'(1);
    end
    if (cmd.key_ld) begin
      key_x_r <= rda_x_r;
      key_y_r <= rda_y_r;
    end
    if (cmd.c_ld) begin
      c_x_r <= rda_x_r;
      c_y_r <= rda_y_r;
    end
    if (cmd.ch_init) begin
      t_r    <= '0;
      s_r    <= '0;
      pass_r <= 1'b0;
      k_r    <= '0;
    end else if (cmd.pass_end) begin
      t_r    <= t_r - TW'(1);
      s_r    <= t_r - TW'(1);
      pass_r <= 1'b1;
      k_r    <= '0;
    end else if (cmd.t_dec) begin
      t_r <= t_r - TW'(1);
    end else if (cmd.push) begin
      if (t_r <= TW'(MAX_POINTS)) begin
        t_r <= t_r + TW'(1);
      end
      k_r <= k_r + CW'(1);
    end
    if (cmd.single || cmd.m_one) begin
      m_r <= TW'(1);
    end else if (cmd.m_from_t) begin
      m_r <= t_r;
    end
    if (cmd.diff_ld) begin
      bx_r <= DW'(rdb_x_r) - DW'(rda_x_r);
      by_r <= DW'(rdb_y_r) - DW'(rda_y_r);
      cx_r <= DW'(c_x_r) - DW'(rda_x_r);
      cy_r <= DW'(c_y_r) - DW'(rda_y_r);
    end
    if (cmd.prod_ld) begin
      p1_r <= bx_r * cy_r;
      p2_r <= by_r * cx_r;
    end
    if (cmd.out_ld) begin
      hx_r    <= rda_x_r;
      hy_r    <= rda_y_r;
      hlast_r <= ({1'b0, i_r} + (CW+1)'(1)) == (CW+1)'(m_r);
      hdrop_r <= ovf_r;
    end
  end

  assign turn = (PW+1)'(p1_r) - (PW+1)'(p2_r);

  assign sts.i_ge_n   = (i_r >= count_r);
  assign sts.j_zero   = (j_r == '0);
  assign sts.key_less = (key_x_r < rda_x_r) ||
                        ((key_x_r == rda_x_r) && (key_y_r < rda_y_r));
  assign sts.n_le1    = (count_r <= CW'(1));
  assign sts.k_ge_n   = (k_r >= count_r);
  assign sts.pass1    = pass_r;
  assign sts.can_pop  = ({1'b0, t_r} >= ({1'b0, s_r} + (TW+1)'(2)));
  assign sts.turn_le0 = (turn <= 0);
  assign sts.t_eq2    = (t_r == TW'(2));
  assign sts.pts_eq   = (rda_x_r == rdb_x_r) && (rda_y_r == rdb_y_r);
  assign sts.out_last = hlast_r;

  assign out_x       = hx_r;
  assign out_y       = hy_r;
  assign out_last    = hlast_r;
  assign out_dropped = hdrop_r;

endmodule

`default_nettype wire

// ----- hdl/convex_hull_monotone_chain.sv -----
// Loading takes one point transfer per cycle. After the marked point, the set of N
// stored points is insertion sorted. The chain builder then walks it twice, with
// a cross-product test for each pop candidate, and each vertex is offered once its
// stack read, its store read and its output register load are done, so a new
// vertex is not offered before the previous vertex transfer is taken.
// Reset (synchronous, active low) empties the set; no memory is cleared.
`default_nettype none

module convex_hull_monotone_chain #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  chm_point_if.sink   in_pt,
  chm_hull_if.source  out_hull
);

  // Command and status bundles between the sequencer and the datapath.
  chm_pkg::cmd_t cmd;
  chm_pkg::sts_t sts;

  // The sequencer owns both handshakes: it takes a point transfer only while
  // loading and presents a vertex only once its coordinates are registered.
  chm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_pt.valid),
    .in_set_end (in_pt.set_end),
    .in_ready   (in_pt.ready),
    .out_valid  (out_hull.valid),
    .out_ready  (out_hull.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // The datapath holds the point store, the chain stack, the loop counters
  // and the cross-product unit.
  chm_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_x        (in_pt.point_x),
    .in_y        (in_pt.point_y),
    .out_x       (out_hull.hull_x),
    .out_y       (out_hull.hull_y),
    .out_last    (out_hull.hull_last),
    .out_dropped (out_hull.points_dropped)
  );

endmodule

`default_nettype wire
